>>> rtl/eis_pkg.sv
// eis_pkg: shared types and constants for the electron isolation sum block.
// No dependencies; imported by every module of the block.

package eis_pkg;

   localparam int MaxCandidates = 1024;
   localparam int CountFieldMax = 2047;
   localparam int PiQ10         = 3217;
   localparam int TwoPiQ10      = 6434;
   localparam int EtaStripQ10   = 26;
   localparam int NhConeSqQ20   = 5139;
   localparam int SumMax        = 16777215;

   localparam logic [10:0] CountCap =
      11'((MaxCandidates > CountFieldMax) ? CountFieldMax : MaxCandidates);

   typedef enum logic [2:0] {
      REG_REF_ETA        = 3'd0,
      REG_REF_PHI        = 3'd1,
      REG_REF_Z          = 3'd2,
      REG_MAX_DZ         = 3'd3,
      REG_NEUTRAL_PT_MIN = 3'd4,
      REG_OUTER_RADIUS   = 3'd5,
      REG_INNER_RADIUS   = 3'd6,
      REG_LEPTON_VETO_ON = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_OTHER          = 2'd0,
      KIND_PHOTON         = 2'd1,
      KIND_NEUTRAL_HADRON = 2'd2
   } kind_type;

   typedef struct packed {
      logic signed [13:0] ref_eta;
      logic signed [12:0] ref_phi;
      logic signed [15:0] ref_z;
      logic [15:0]        max_dz;
      logic [15:0]        neutral_pt_min;
      logic [25:0]        outer_sq;
      logic [25:0]        inner_sq;
      logic               lepton_veto_on;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        pt;
      logic signed [13:0] eta;
      logic signed [12:0] phi;
      logic signed [15:0] z;
      logic               has_track;
      logic [1:0]         kind;
      logic               shares_ref_track;
      logic               matches_good_lepton;
      logic               last_cand;
   } cand_type;

   typedef struct packed {
      logic [15:0] pt;
      logic        pass;
      logic        last;
   } verdict_type;

endpackage

>>> rtl/pf_electron_isolation_sum.sv
// pf_electron_isolation_sum: top level of the electron cone isolation sum.
// Depends on eis_pkg, eis_csr, eis_filter and eis_accum.

// Streams particle candidates at one item per clock and sums the pt of those
// that pass the cuts around the configured reference electron; the candidate
// flagged by req_tlast closes the run and yields one result item with the
// saturated sum and the accepted count. An item passes the input register and
// the cut logic, then the verdict register and the accumulator, which registers
// the result. The accumulator register is the only feedback loop, so the
// block holds one item per clock unless a result sits unread on the output
// while a further last candidate arrives.
module pf_electron_isolation_sum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] cand_pt, [29:16] cand_eta, [42:30] cand_phi, [58:43] cand_z
   input  logic [63:0] req_tdata,
   // [0] has_track, [2:1] cand_kind, [3] shares_ref_track, [4] matches_good_lepton
   input  logic [4:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [23:0] iso_sum, [34:24] accepted_count
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import eis_pkg::*;

   cfg_type     cfg;
   cand_type    cand;
   verdict_type vd;
   logic        vd_valid;
   logic        vd_take;
   logic [23:0] iso_sum;
   logic [10:0] accepted_count;

   assign cand.pt                  = req_tdata[15:0];
   assign cand.eta                 = req_tdata[29:16];
   assign cand.phi                 = req_tdata[42:30];
   assign cand.z                   = req_tdata[58:43];
   assign cand.has_track           = req_tuser[0];
   assign cand.kind                = req_tuser[2:1];
   assign cand.shares_ref_track    = req_tuser[3];
   assign cand.matches_good_lepton = req_tuser[4];
   assign cand.last_cand           = req_tlast;

   eis_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   eis_filter u_filter (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cand  (cand),
      .vd_valid (vd_valid),
      .vd       (vd),
      .vd_take  (vd_take)
   );

   eis_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .vd_valid  (vd_valid),
      .vd        (vd),
      .vd_take   (vd_take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_sum   (iso_sum),
      .out_count (accepted_count)
   );

   assign rsp_tdata = {5'd0, accepted_count, iso_sum};

endmodule

>>> rtl/eis_csr.sv
// eis_csr: configuration registers of the electron isolation sum block.
// Depends on eis_pkg; radius squares are kept precomputed.

module eis_csr (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [2:0]     csr_index,
   input  logic [15:0]    csr_data,
   output eis_pkg::cfg_type cfg
);
   import eis_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [12:0] radius;
   logic [25:0] radius_sq;

   assign csr_ready = 1'b1;
   assign radius    = csr_data[12:0];
   assign radius_sq = 26'(radius) * 26'(radius);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_REF_ETA:        cfg_in.ref_eta        = csr_data[13:0];
            REG_REF_PHI:        cfg_in.ref_phi        = csr_data[12:0];
            REG_REF_Z:          cfg_in.ref_z          = csr_data;
            REG_MAX_DZ:         cfg_in.max_dz         = csr_data;
            REG_NEUTRAL_PT_MIN: cfg_in.neutral_pt_min = csr_data;
            REG_OUTER_RADIUS:   cfg_in.outer_sq       = radius_sq;
            REG_INNER_RADIUS:   cfg_in.inner_sq       = radius_sq;
            REG_LEPTON_VETO_ON: cfg_in.lepton_veto_on = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_eta        <= '0;
         cfg_ff.ref_phi        <= '0;
         cfg_ff.ref_z          <= '0;
         cfg_ff.max_dz         <= 16'd205;
         cfg_ff.neutral_pt_min <= '0;
         cfg_ff.outer_sq       <= 26'd168100;
         cfg_ff.inner_sq       <= '0;
         cfg_ff.lepton_veto_on <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/eis_filter.sv
// eis_filter: input register and candidate selection cuts.
// Depends on eis_pkg; feeds a verdict register to eis_accum.

module eis_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  eis_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  eis_pkg::cand_type    in_cand,
   output logic                 vd_valid,
   output eis_pkg::verdict_type vd,
   input  logic                 vd_take
);
   import eis_pkg::*;

   logic        a_valid_ff, a_valid_in;
   cand_type    a_ff;
   logic        b_valid_ff, b_valid_in;
   verdict_type b_ff, b_in;
   logic        b_free;

   logic signed [14:0] deta;
   logic signed [13:0] dphi_raw, dphi;
   logic signed [16:0] dz;
   logic [13:0]        adeta;
   logic [12:0]        adphi;
   logic [15:0]        adz;
   logic [27:0]        deta_sq;
   logic [25:0]        dphi_sq;
   logic [28:0]        dr2;
   logic               pass;

   assign b_free   = !b_valid_ff || vd_take;
   assign in_ready = !a_valid_ff || b_free;

   assign deta     = 15'(a_ff.eta) - 15'(cfg.ref_eta);
   assign dphi_raw = 14'(a_ff.phi) - 14'(cfg.ref_phi);
   assign dz       = 17'(a_ff.z) - 17'(cfg.ref_z);

   always_comb begin
      if (dphi_raw > 14'(PiQ10)) begin
         dphi = dphi_raw - 14'(TwoPiQ10);
      end else if (dphi_raw < -14'(PiQ10)) begin
         dphi = dphi_raw + 14'(TwoPiQ10);
      end else begin
         dphi = dphi_raw;
      end
   end

   assign adeta   = deta[14] ? 14'(-deta) : deta[13:0];
   assign adphi   = dphi[13] ? 13'(-dphi) : dphi[12:0];
   assign adz     = dz[16] ? 16'(-dz) : dz[15:0];
   assign deta_sq = 28'(adeta) * 28'(adeta);
   assign dphi_sq = 26'(adphi) * 26'(adphi);
   assign dr2     = 29'(deta_sq) + 29'(dphi_sq);

   always_comb begin
      pass = 1'b1;
      if (!a_ff.has_track && a_ff.pt <= cfg.neutral_pt_min) pass = 1'b0;
      if (a_ff.shares_ref_track) pass = 1'b0;
      if (a_ff.has_track && adz >= cfg.max_dz) pass = 1'b0;
      if (!(dr2 < 29'(cfg.outer_sq) && dr2 >= 29'(cfg.inner_sq))) pass = 1'b0;
      if (a_ff.kind == KIND_PHOTON && adeta < 14'(EtaStripQ10)) pass = 1'b0;
      if (!a_ff.has_track && a_ff.kind == KIND_NEUTRAL_HADRON &&
          dr2 < 29'(NhConeSqQ20)) pass = 1'b0;
      if (cfg.lepton_veto_on && a_ff.matches_good_lepton) pass = 1'b0;
   end

   always_comb begin
      a_valid_in = in_ready ? in_valid : a_valid_ff;
      b_valid_in = b_free ? a_valid_ff : b_valid_ff;
      b_in.pt    = a_ff.pt;
      b_in.pass  = pass;
      b_in.last  = a_ff.last_cand;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_ff <= in_cand;
      end
      if (b_free && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign vd_valid = b_valid_ff;
   assign vd       = b_ff;

endmodule

>>> rtl/eis_accum.sv
// eis_accum: saturating pt sum and count, result register.
// Depends on eis_pkg; takes verdicts from eis_filter.

module eis_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 vd_valid,
   input  eis_pkg::verdict_type vd,
   output logic                 vd_take,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [23:0]          out_sum,
   output logic [10:0]          out_count
);
   import eis_pkg::*;

   logic [23:0] sum_ff, sum_in, sum_upd;
   logic [10:0] count_ff, count_in, count_upd;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_sum_ff;
   logic [10:0] rsp_count_ff;
   logic [24:0] add;
   logic        flush;

   assign vd_take = vd_valid && (!vd.last || !rsp_valid_ff || out_ready);
   assign flush   = vd_take && vd.last;
   assign add     = 25'(sum_ff) + 25'(vd.pt);

   always_comb begin
      sum_upd   = sum_ff;
      count_upd = count_ff;
      if (vd.pass) begin
         sum_upd = add[24] ? 24'(SumMax) : add[23:0];
         if (count_ff < CountCap) count_upd = count_ff + 11'd1;
      end
      sum_in   = sum_ff;
      count_in = count_ff;
      if (vd_take) begin
         sum_in   = vd.last ? '0 : sum_upd;
         count_in = vd.last ? '0 : count_upd;
      end
      rsp_valid_in = flush ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flush) begin
         rsp_sum_ff   <= sum_upd;
         rsp_count_ff <= count_upd;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_sum   = rsp_sum_ff;
   assign out_count = rsp_count_ff;

endmodule

>>> rtl/eis_checker.sv
// eis_checker: port-level checks for pf_electron_isolation_sum.
// Depends on eis_pkg; bound to the top level at the end of this file.

module eis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import eis_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // input backpressure only comes from an unread result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:24] <= CountCap)
      else $error("accepted count above cap");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:24] == 11'd0 |-> rsp_tdata[23:0] == 24'd0)
      else $error("nonzero sum with no accepted items");

endmodule

bind pf_electron_isolation_sum eis_checker u_eis_checker (.*);
